FILE: hdl/aunp_pkg.sv
// ----------------------------------------------------------------------------
// aunp_pkg: shared types and constants for the ARGB32 unpremultiply block
// Item formats between the front end, the queue and the divider back end.
// ----------------------------------------------------------------------------
package aunp_pkg;

	// channel and datapath widths
	localparam int unsigned CH_W    = 8;
	localparam int unsigned NUM_W   = 17;   // 510*c + a for c, a <= 255
	localparam int unsigned NCH     = 3;    // red, green, blue
	localparam int unsigned QUO_W   = 8;    // quotient bits, one per divider step
	localparam int unsigned CFG_IDX_W = 8;

	// color channel slots inside the arrays below
	localparam int unsigned CH_RED   = 2;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE  = 0;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_RED_BLUE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FORCE_OPAQUE  = 8'd1;

	localparam logic [CH_W-1:0] CH_MAX = 8'hff;

	// configuration state
	typedef struct packed {
		logic swap_red_blue;
		logic force_opaque;
	} cfg_t;

	// classified pixel, front end to back end
	typedef struct packed {
		logic [CH_W-1:0]            alpha;
		logic                       end_of_run;
		logic                       zero_alpha;
		logic [NCH-1:0]             sat;
		logic [NCH-1:0][NUM_W-1:0]  num;
	} cls_t;

	// divider pipeline word
	typedef struct packed {
		logic [CH_W-1:0]            alpha;
		logic                       end_of_run;
		logic                       zero_alpha;
		logic [NCH-1:0]             sat;
		logic [NCH-1:0][NUM_W-1:0]  rem;
		logic [NCH-1:0][QUO_W-1:0]  quo;
	} div_t;

endpackage

FILE: hdl/aunp_front.sv
// ----------------------------------------------------------------------------
// aunp_front: input stage
// Takes a pixel, flags the transparent and saturating cases and forms the
// rounded-division numerators, then hands the item on to the queue.
// ----------------------------------------------------------------------------
module aunp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [31:0]         pixel_in,
	input  logic                end_of_run,
	output logic                item_valid,
	input  logic                item_ready,
	output aunp_pkg::cls_t      item
);

	logic           v_s1;
	aunp_pkg::cls_t item_s1;
	aunp_pkg::cls_t cls;
	logic           take;
	logic [7:0]     a;
	logic [7:0]     c [0:2];

	assign full = v_s1 && !item_ready;
	assign take = push && !full;

	assign a    = pixel_in[31:24];
	assign c[aunp_pkg::CH_RED]   = pixel_in[23:16];
	assign c[aunp_pkg::CH_GREEN] = pixel_in[15:8];
	assign c[aunp_pkg::CH_BLUE]  = pixel_in[7:0];

	// classify: channel above alpha saturates, numerator = 510*c + a
	always_comb begin
		cls.alpha      = a;
		cls.end_of_run = end_of_run;
		cls.zero_alpha = (a == 8'd0);
		for (int i = 0; i < aunp_pkg::NCH; i++) begin
			cls.sat[i] = (c[i] > a);
			cls.num[i] = {c[i], 9'd0} - {8'd0, c[i], 1'b0} + {9'd0, a};
		end
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!full) begin
			v_s1 <= push;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= cls;
		end
	end

	assign item_valid = v_s1;
	assign item       = item_s1;

endmodule

FILE: hdl/aunp_fifo.sv
// ----------------------------------------------------------------------------
// aunp_fifo: two-entry queue of classified pixels
// Lets the front end and the divider back end stall independently.
// ----------------------------------------------------------------------------
module aunp_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  aunp_pkg::cls_t  wr_item,
	output logic            rd_valid,
	input  logic            rd_take,
	output aunp_pkg::cls_t  rd_item
);

	aunp_pkg::cls_t mem_q [0:1];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_wr;
	logic           do_rd;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_take && rd_valid;
	assign rd_item  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

FILE: hdl/aunp_back.sv
// ----------------------------------------------------------------------------
// aunp_back: divider pipeline and result register
// Eight restoring-division steps, one quotient bit per step for all three
// channels, then saturation, alpha fixup and byte swap into the result.
// ----------------------------------------------------------------------------
module aunp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  aunp_pkg::cfg_t  cfg,
	input  logic            item_valid,
	output logic            item_take,
	input  aunp_pkg::cls_t  item,
	output logic            empty,
	input  logic            pop,
	output logic [31:0]     pixel_out,
	output logic            end_of_run_out
);

	localparam int unsigned NSTG = aunp_pkg::QUO_W;

	aunp_pkg::div_t pipe_s [0:NSTG-1];
	logic [NSTG-1:0] pv_s;
	logic            out_valid_q;
	logic [31:0]     pixel_q;
	logic            eor_q;
	logic            advance;
	aunp_pkg::div_t  head;
	aunp_pkg::div_t  last;
	logic [7:0]      ch [0:2];
	logic [7:0]      alpha_o;

	// one restoring step: subtract (2a << k) when it fits, set quotient bit k
	function automatic aunp_pkg::div_t div_step(input aunp_pkg::div_t d,
	                                            input logic [2:0] k);
		aunp_pkg::div_t         r;
		logic [aunp_pkg::NUM_W-1:0] trial;
		r     = d;
		trial = {{(aunp_pkg::NUM_W-9){1'b0}}, d.alpha, 1'b0} << k;
		for (int i = 0; i < aunp_pkg::NCH; i++) begin
			if (d.rem[i] >= trial) begin
				r.rem[i]    = d.rem[i] - trial;
				r.quo[i][k] = 1'b1;
			end
		end
		return r;
	endfunction

	// whole pipeline moves when the result slot is free or being taken
	assign advance   = !out_valid_q || pop;
	assign item_take = advance;

	always_comb begin
		head.alpha      = item.alpha;
		head.end_of_run = item.end_of_run;
		head.zero_alpha = item.zero_alpha;
		head.sat        = item.sat;
		head.rem        = item.num;
		head.quo        = '0;
	end

	// stage valids and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s        <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			pv_s        <= {pv_s[NSTG-2:0], item_valid};
			out_valid_q <= pv_s[NSTG-1];
		end
	end

	// divider stages: stage 0 loads the numerators, stage j > 0 resolves quotient bit NSTG-j
	always_ff @(posedge clk) begin
		if (advance) begin
			pipe_s[0] <= head;
			for (int j = 1; j < NSTG; j++) begin
				pipe_s[j] <= div_step(pipe_s[j-1], 3'(NSTG - j));
			end
		end
	end

	// last step, then saturation and transparent override
	assign last = div_step(pipe_s[NSTG-1], 3'd0);

	always_comb begin
		for (int i = 0; i < aunp_pkg::NCH; i++) begin
			if (last.zero_alpha) begin
				ch[i] = 8'd0;
			end else if (last.sat[i]) begin
				ch[i] = aunp_pkg::CH_MAX;
			end else begin
				ch[i] = last.quo[i];
			end
		end
		alpha_o = cfg.force_opaque ? aunp_pkg::CH_MAX : last.alpha;
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			eor_q <= last.end_of_run;
			if (cfg.swap_red_blue) begin
				pixel_q <= {alpha_o, ch[aunp_pkg::CH_BLUE], ch[aunp_pkg::CH_GREEN],
				            ch[aunp_pkg::CH_RED]};
			end else begin
				pixel_q <= {alpha_o, ch[aunp_pkg::CH_RED], ch[aunp_pkg::CH_GREEN],
				            ch[aunp_pkg::CH_BLUE]};
			end
		end
	end

	assign empty          = !out_valid_q;
	assign pixel_out      = pixel_q;
	assign end_of_run_out = eor_q;

endmodule

FILE: hdl/argb32_alpha_unpremultiply.sv
// ----------------------------------------------------------------------------
// argb32_alpha_unpremultiply: premultiplied ARGB32 to straight ARGB32
// Converts one pixel per clock. Each color channel becomes c*255/a, rounded
// to nearest with ties up and saturated at 255; alpha 0 gives black, alpha
// 255 passes the color. Alpha can be forced to 255 and red/blue swapped.
//
// Throughput is one pixel per clock while pop keeps up. An accepted pixel
// first loads the input stage, then is written into the two-entry queue,
// then moves through the divider pipeline registers: the first only loads
// the numerators, and each later one resolves one quotient bit for all
// three channels. The last quotient bit is resolved ahead of the result
// register, which drives the result ports. Configuration writes are always
// accepted and take effect on the next result registered, so write them
// only while no item is in flight.
// ----------------------------------------------------------------------------
module argb32_alpha_unpremultiply (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [31:0]                        pixel_in,
	input  logic                               end_of_run,
	output logic                               empty,
	input  logic                               pop,
	output logic [31:0]                        pixel_out,
	output logic                               end_of_run_out,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [aunp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic                               cfg_data
);

	aunp_pkg::cfg_t cfg_q;
	aunp_pkg::cls_t front_item;
	aunp_pkg::cls_t back_item;
	logic           front_valid;
	logic           front_ready;
	logic           back_valid;
	logic           back_take;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				aunp_pkg::REG_SWAP_RED_BLUE: cfg_q.swap_red_blue <= cfg_data;
				aunp_pkg::REG_FORCE_OPAQUE:  cfg_q.force_opaque  <= cfg_data;
				default: ;
			endcase
		end
	end

	aunp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.pixel_in   (pixel_in),
		.end_of_run (end_of_run),
		.item_valid (front_valid),
		.item_ready (front_ready),
		.item       (front_item)
	);

	aunp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_item  (front_item),
		.rd_valid (back_valid),
		.rd_take  (back_take),
		.rd_item  (back_item)
	);

	aunp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.item_valid     (back_valid),
		.item_take      (back_take),
		.item           (back_item),
		.empty          (empty),
		.pop            (pop),
		.pixel_out      (pixel_out),
		.end_of_run_out (end_of_run_out)
	);

endmodule
